// ===== design/ufcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ufcd_pkg
// Shared types and constants for the union-find cycle detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ufcd_pkg;

	localparam int DEF_MAX_VERTICES = 256;

	localparam int VCOUNT_W = 9;
	localparam int VERTEX_W = 8;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_EDGE  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SRC_WALK,
		ST_DST_WALK,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic start;
		logic operation;
		logic range_err;
		logic node_root;
	} status_t;

	typedef struct packed {
		logic busy;
		logic acc_clear;
		logic acc_error;
		logic acc_edge;
		logic clr_step;
		logic src_root;
		logic src_link;
		logic dst_link;
		logic update;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== design/union_find_cycle_detector.sv =====
// Clear item: busy while the sweep writes every forest entry, one per cycle, with the
// result strobe in the cycle after. Out-of-range edge: result in the next cycle.
// Edge item: busy while it walks from each endpoint to its root, one
// parent-table read per link, and then for the update step.
// A new item can be started in the cycle that carries the result strobe.
// Reset runs a clearing pass with busy high.
// ----------------------------------------------------------------------------
// union_find_cycle_detector
// Streamed-edge cycle detector over a quick-union forest without compression.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_cycle_detector import ufcd_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                operation,
	input  wire logic [VERTEX_W-1:0] src_vertex,
	input  wire logic [VERTEX_W-1:0] dest_vertex,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [VCOUNT_W-1:0] cfg_data,
	output logic                     done,
	output logic                     closes_cycle,
	output logic                     cycle_seen,
	output logic                     range_error
);

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int ENT_W = IDX_W + 1;
	localparam bit NARROW = MAX_VERTICES < 256;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VERTICES - 1);

	status_t status;
	ctrl_t   ctrl;

	logic [VCOUNT_W-1:0] vcount_q;
	logic [IDX_W-1:0]    clr_idx_q;
	logic                clr_cmd_q;
	logic                cycle_flag_q;
	logic [IDX_W-1:0]    cur_q;
	logic [IDX_W-1:0]    dst_q;
	logic [IDX_W-1:0]    src_root_q;
	logic                done_q;
	logic                closes_q;
	logic                seen_q;
	logic                err_q;

	logic                range_err;
	logic                clr_last;
	logic                roots_eq;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [ENT_W-1:0]    ram_rdata;
	logic                node_root;
	logic [IDX_W-1:0]    node_parent;

	assign node_root   = ram_rdata[IDX_W];
	assign node_parent = ram_rdata[IDX_W-1:0];

	always_comb begin
		range_err = ({1'b0, src_vertex} >= vcount_q) || ({1'b0, dest_vertex} >= vcount_q);
		if (NARROW) begin
			range_err = range_err || (32'(src_vertex) >= 32'(MAX_VERTICES))
				|| (32'(dest_vertex) >= 32'(MAX_VERTICES));
		end
	end

	assign status.start     = start;
	assign status.operation = operation;
	assign status.range_err = range_err;
	assign status.node_root = node_root;

	assign clr_last = ctrl.clr_step && (clr_idx_q == LAST_IDX);
	assign roots_eq = (src_root_q == cur_q);

	ufcd_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.clr_last (clr_last),
		.ctrl     (ctrl)
	);

	// read address: start vertex, next parent, or second endpoint
	always_comb begin
		ram_raddr = cur_q;
		if (ctrl.acc_edge) begin
			ram_raddr = IDX_W'(src_vertex);
		end else if (ctrl.src_root) begin
			ram_raddr = dst_q;
		end else if (ctrl.src_link || ctrl.dst_link) begin
			ram_raddr = node_parent;
		end
	end

	always_comb begin
		ram_we    = ctrl.clr_step || (ctrl.update && !roots_eq && !cycle_flag_q);
		ram_waddr = ctrl.clr_step ? clr_idx_q : src_root_q;
		ram_wdata = ctrl.clr_step ? {1'b1, {IDX_W{1'b0}}} : {1'b0, cur_q};
	end

	ufcd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= VCOUNT_RESET;
			clr_idx_q    <= '0;
			clr_cmd_q    <= 1'b0;
			cycle_flag_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (ctrl.acc_clear) begin
				clr_idx_q    <= '0;
				clr_cmd_q    <= 1'b1;
				cycle_flag_q <= 1'b0;
			end
			if (ctrl.clr_step) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_last) begin
					clr_cmd_q <= 1'b0;
					done_q    <= clr_cmd_q;
				end
			end
			if (ctrl.acc_error || ctrl.update) begin
				done_q <= 1'b1;
			end
			if (ctrl.update && roots_eq) begin
				cycle_flag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_edge) begin
			cur_q <= IDX_W'(src_vertex);
			dst_q <= IDX_W'(dest_vertex);
		end else if (ctrl.src_root) begin
			src_root_q <= cur_q;
			cur_q      <= dst_q;
		end else if (ctrl.src_link || ctrl.dst_link) begin
			cur_q <= node_parent;
		end
		if (ctrl.clr_step) begin
			closes_q <= 1'b0;
			seen_q   <= 1'b0;
			err_q    <= 1'b0;
		end else if (ctrl.acc_error) begin
			closes_q <= 1'b0;
			seen_q   <= cycle_flag_q;
			err_q    <= 1'b1;
		end else if (ctrl.update) begin
			closes_q <= roots_eq;
			seen_q   <= roots_eq || cycle_flag_q;
			err_q    <= 1'b0;
		end
	end

	assign busy         = ctrl.busy;
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign closes_cycle = closes_q;
	assign cycle_seen   = seen_q;
	assign range_error  = err_q;

endmodule

`default_nettype wire

// ===== design/ufcd_ram.sv =====
// ----------------------------------------------------------------------------
// ufcd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ufcd_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/ufcd_fsm.sv =====
// ----------------------------------------------------------------------------
// ufcd_fsm
// Sequencer for clearing sweep, the two root walks and the final link.
// ----------------------------------------------------------------------------
`default_nettype none

module ufcd_fsm import ufcd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t status,
	input  wire logic    clr_last,
	output ctrl_t        ctrl
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (status.start) begin
					if (status.operation == OP_CLEAR) begin
						state_next = ST_CLEAR;
					end else if (!status.range_err) begin
						state_next = ST_SRC_WALK;
					end
				end
			end
			ST_SRC_WALK: begin
				if (status.node_root) begin
					state_next = ST_DST_WALK;
				end
			end
			ST_DST_WALK: begin
				if (status.node_root) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_CLEAR: begin
				ctrl.busy     = 1'b1;
				ctrl.clr_step = 1'b1;
			end
			ST_IDLE: begin
				ctrl.acc_clear = status.start && (status.operation == OP_CLEAR);
				ctrl.acc_error = status.start && (status.operation == OP_EDGE)
					&& status.range_err;
				ctrl.acc_edge  = status.start && (status.operation == OP_EDGE)
					&& !status.range_err;
			end
			ST_SRC_WALK: begin
				ctrl.busy     = 1'b1;
				ctrl.src_root = status.node_root;
				ctrl.src_link = !status.node_root;
			end
			ST_DST_WALK: begin
				ctrl.busy     = 1'b1;
				ctrl.dst_link = !status.node_root;
			end
			ST_UPDATE: begin
				ctrl.busy   = 1'b1;
				ctrl.update = 1'b1;
			end
			default: begin
				ctrl.busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ufcd_checker.sv =====
// ----------------------------------------------------------------------------
// ufcd_checker
// Port-level checks for the union-find cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ufcd_checker import ufcd_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                operation,
	input wire logic                done,
	input wire logic                closes_cycle,
	input wire logic                cycle_seen,
	input wire logic                range_error
);

	// a cycle-closing edge is never an ignored edge
	a_close_not_err: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(closes_cycle && range_error))
		else $error("closes_cycle with range_error");

	// sticky flag follows any closing edge
	a_close_sets_seen: assert property (@(posedge clk) disable iff (!arst_n)
		done && closes_cycle |-> cycle_seen)
		else $error("closes_cycle without cycle_seen");

	// clear transfer starts a sweep with busy high and no result strobe
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_CLEAR) |=> busy && !done)
		else $error("clear did not start sweep");

	// edge transfer either walks or reports a range error at once
	a_edge_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_EDGE) |=> busy || (done && range_error))
		else $error("edge transfer neither walking nor rejected");

endmodule

bind union_find_cycle_detector ufcd_checker u_ufcd_checker (.*);

`default_nettype wire

// ===== sim/union_find_cycle_detector_test.sv =====
// ----------------------------------------------------------------------------
// union_find_cycle_detector_test
// Self-checking bench for the streamed-edge cycle detector. A quick-union
// forest kept in the bench predicts closes_cycle, cycle_seen and range_error
// for each accepted command. Directed cases are followed by random graphs
// with random vertex counts, under several sender idle ratios.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_cycle_detector_test;
	import ufcd_pkg::*;

	localparam int NV = DEF_MAX_VERTICES;

	typedef struct packed {
		logic closes_cycle;
		logic cycle_seen;
		logic range_error;
	} verdict_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [VERTEX_W-1:0] src_vertex;
	logic [VERTEX_W-1:0] dest_vertex;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [VCOUNT_W-1:0] cfg_data;
	logic                done;
	logic                closes_cycle;
	logic                cycle_seen;
	logic                range_error;

	// forest copy
	logic                is_root [NV];
	logic [VERTEX_W-1:0] parent_of [NV];
	logic                cycle_flag;
	logic [VCOUNT_W-1:0] vertex_count;

	verdict_t verdict_q [$];
	int       mismatches;
	int       sender_idle_pct;

	union_find_cycle_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.src_vertex   (src_vertex),
		.dest_vertex  (dest_vertex),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.closes_cycle (closes_cycle),
		.cycle_seen   (cycle_seen),
		.range_error  (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void clear_forest();
		for (int k = 0; k < NV; k++) begin
			is_root[k] = 1'b1;
			parent_of[k] = '0;
		end
		cycle_flag = 1'b0;
	endfunction

	function automatic logic [VERTEX_W-1:0] find_root(input logic [VERTEX_W-1:0] v);
		logic [VERTEX_W-1:0] node;
		int steps;
		node = v;
		steps = 0;
		while (!is_root[node] && steps < NV) begin
			node = parent_of[node];
			steps++;
		end
		return node;
	endfunction

	function automatic verdict_t apply_command(input logic op, input logic [VERTEX_W-1:0] s,
			input logic [VERTEX_W-1:0] d);
		verdict_t r;
		int limit;
		logic [VERTEX_W-1:0] rs;
		logic [VERTEX_W-1:0] rd;
		r = '0;
		limit = (vertex_count > NV) ? NV : int'(vertex_count);
		if (op == OP_CLEAR) begin
			clear_forest();
			return r;
		end
		if (int'(s) >= limit || int'(d) >= limit) begin
			r.cycle_seen = cycle_flag;
			r.range_error = 1'b1;
			return r;
		end
		rs = find_root(s);
		rd = find_root(d);
		if (rs == rd) begin
			cycle_flag = 1'b1;
			r.closes_cycle = 1'b1;
		end else if (!cycle_flag) begin
			is_root[rs] = 1'b0;
			parent_of[rs] = rd;
		end
		r.cycle_seen = cycle_flag;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("result with no command pending");
			end else begin
				want = verdict_q.pop_front();
				if (closes_cycle !== want.closes_cycle)
					report_mismatch($sformatf("closes_cycle %b, expected %b",
						closes_cycle, want.closes_cycle));
				if (cycle_seen !== want.cycle_seen)
					report_mismatch($sformatf("cycle_seen %b, expected %b",
						cycle_seen, want.cycle_seen));
				if (range_error !== want.range_error)
					report_mismatch($sformatf("range_error %b, expected %b",
						range_error, want.range_error));
			end
		end
	end

	task automatic send_command(input logic op, input logic [VERTEX_W-1:0] s,
			input logic [VERTEX_W-1:0] d);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		src_vertex <= s;
		dest_vertex <= d;
		do @(posedge clk); while (busy);
		verdict_q.push_back(apply_command(op, s, d));
	endtask

	task automatic send_edge(input logic [VERTEX_W-1:0] s, input logic [VERTEX_W-1:0] d);
		send_command(OP_EDGE, s, d);
	endtask

	task automatic send_clear();
		send_command(OP_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		vertex_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_edge_extremes();
		write_vertex_count(9'd256);
		send_clear();
		send_edge(8'd0, 8'd255);
		send_edge(8'd255, 8'd0);
		send_edge(8'd255, 8'd255);
		send_clear();
		send_edge(8'd128, 8'd127);
		send_edge(8'd170, 8'd85);
	endtask

	task automatic test_range_errors();
		write_vertex_count(9'd10);
		send_clear();
		send_edge(8'd10, 8'd3);
		send_edge(8'd3, 8'd10);
		send_edge(8'd9, 8'd0);
		send_edge(8'd0, 8'd9);
		send_edge(8'd255, 8'd255);
		write_vertex_count(9'd0);
		send_edge(8'd0, 8'd0);
		write_vertex_count(9'd1);
		send_clear();
		send_edge(8'd0, 8'd0);
		send_edge(8'd0, 8'd1);
	endtask

	task automatic test_count_saturation();
		write_vertex_count(9'd511);
		send_clear();
		send_edge(8'd255, 8'd0);
		write_vertex_count(9'd257);
		send_edge(8'd0, 8'd255);
	endtask

	task automatic test_no_union_after_cycle();
		write_vertex_count(9'd256);
		send_clear();
		send_edge(8'd1, 8'd1);
		send_edge(8'd2, 8'd3);
		send_edge(8'd3, 8'd2);
	endtask

	task automatic test_forest_kept_across_count();
		write_vertex_count(9'd256);
		send_clear();
		send_edge(8'd3, 8'd200);
		send_edge(8'd5, 8'd201);
		write_vertex_count(9'd16);
		send_edge(8'd3, 8'd5);
		send_edge(8'd5, 8'd3);
	endtask

	task automatic test_random_graphs(input int idle_pct, input int commands);
		int sent;
		int pick;
		int lim;
		int n_edges;
		logic [VCOUNT_W-1:0] count;
		sent = 0;
		sender_idle_pct = idle_pct;
		while (sent < commands) begin
			pick = $urandom_range(99);
			if (pick < 60)      count = VCOUNT_W'($urandom_range(2, 24));
			else if (pick < 75) count = VCOUNT_W'($urandom_range(25, 255));
			else if (pick < 85) count = 9'd256;
			else if (pick < 90) count = 9'd1;
			else if (pick < 94) count = 9'd0;
			else                count = VCOUNT_W'($urandom_range(257, 511));
			write_vertex_count(count);
			lim = (count > NV) ? NV : int'(count);
			// phase-local idle switching: some graphs run back to back
			sender_idle_pct = ($urandom_range(3) == 0) ? 0 : idle_pct;
			if ($urandom_range(9) != 0) begin
				send_clear();
				sent++;
			end
			if ($urandom_range(99) < 3 && lim == NV) begin
				// long chain: every walk from vertex 0 goes the whole way down
				n_edges = $urandom_range(16, NV - 1);
				for (int i = 1; i <= n_edges; i++)
					send_edge(8'd0, VERTEX_W'(i));
				send_edge(VERTEX_W'(n_edges), 8'd0);
				sent += n_edges + 1;
			end else begin
				n_edges = $urandom_range(1, 2 * ((lim > 24) ? 24 : lim) + 4);
				for (int i = 0; i < n_edges; i++) begin
					if (lim == 0 || $urandom_range(9) == 0)
						send_command($urandom_range(7) != 0, VERTEX_W'($urandom),
							VERTEX_W'($urandom));
					else
						send_edge(VERTEX_W'($urandom_range(lim - 1)),
							VERTEX_W'($urandom_range(lim - 1)));
				end
				sent += n_edges;
			end
		end
		sender_idle_pct = idle_pct;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_CLEAR;
		src_vertex = '0;
		dest_vertex = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		clear_forest();
		vertex_count = VCOUNT_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_edge_extremes();
		test_range_errors();
		test_count_saturation();
		test_no_union_after_cycle();
		test_forest_kept_across_count();
		sender_idle_pct = 63;
		test_forest_kept_across_count();

		test_random_graphs(0, 300);
		test_random_graphs(63, 290);
		test_random_graphs(0, 290);
		test_random_graphs(33, 290);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/ufcd_pkg.sv
design/ufcd_ram.sv
design/ufcd_fsm.sv
design/union_find_cycle_detector.sv
design/ufcd_checker.sv
sim/union_find_cycle_detector_test.sv
